[hw/rtl/srtfo_pkg.sv]
// Package for the section RVA to file offset translator.
// Holds the transaction structs, command, region and register codes and the state type.
// No dependencies.
`default_nettype none

package srtfo_pkg;

    // One input transaction.
    typedef struct packed {
        logic        command;
        logic [3:0]  slot;
        logic [31:0] section_virtual_start;
        logic [31:0] section_raw_size;
        logic [31:0] section_raw_pointer;
        logic [31:0] rva;
        logic [63:0] add_position;
    } t_in_item;

    // One result transaction.
    typedef struct packed {
        logic [63:0] raw_offset;
        logic [1:0]  region;
        logic        cache_hit;
    } t_out_item;

    // One entry of the section table.
    typedef struct packed {
        logic [31:0] virtual_start;
        logic [31:0] raw_size;
        logic [31:0] raw_pointer;
    } t_slot;

    localparam logic       CMD_LOAD      = 1'b0;
    localparam logic       CMD_TRANSLATE = 1'b1;

    localparam logic [1:0] REGION_HEADER    = 2'd0;
    localparam logic [1:0] REGION_SECTION   = 2'd1;
    localparam logic [1:0] REGION_NOT_FOUND = 2'd2;

    localparam logic       CFG_HEADER_SIZE   = 1'b0;
    localparam logic       CFG_SECTION_COUNT = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SEARCH,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

[hw/rtl/section_rva_to_file_offset.sv]
// Section RVA to file offset translator, top level.
// Depends on srtfo_pkg for the transaction structs, codes and state type.
//
// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_stall   i_in_data  (t_in_item)
// out       output     o_out_valid / i_out_stall o_out_data (t_out_item)
// cfg       input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
// A load writes the table when accepted. A translate goes from S_CHECK to S_DONE when the
// header area or the cached window answers; when the section table is searched, S_SEARCH
// covers up to section_count slots (at most SECTION_SLOTS), one slot read from the table
// memory per cycle. Synchronous reset clears the control, configuration and output valid
// registers and the cached window; the section table is not cleared. A result waits in the
// output register while the consumer stalls, and the next transaction is taken meanwhile.
`default_nettype none

module section_rva_to_file_offset
    import srtfo_pkg::*;
#(
    parameter int SECTION_SLOTS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out_data,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

    localparam int AW = (SECTION_SLOTS > 1) ? $clog2(SECTION_SLOTS) : 1;
    localparam int CW = $clog2(SECTION_SLOTS + 1);

    // Section table memory, synchronous read.
    t_slot r_mem [SECTION_SLOTS];
    t_slot r_rd_data;

    t_state r_state, n_state;

    logic [31:0] r_header_size;
    logic [4:0]  r_section_count;

    // Cached window: start, end and pointer minus start.
    logic [31:0] r_win_start;
    logic [32:0] r_win_end;
    logic [32:0] r_win_delta;

    logic [31:0] r_rva;
    logic [63:0] r_base;
    logic [1:0]  r_region;
    logic        r_hit;

    logic [CW-1:0] r_idx;
    logic          r_rd_valid;
    logic          r_rd_last;

    logic        r_out_valid;
    t_out_item   r_out_data;

    logic          w_in_accept;
    logic          w_issue;
    logic          w_out_load;
    logic [CW-1:0] w_lim;
    logic          w_header;
    logic          w_cache_hit;
    logic [32:0]   w_slot_end;
    logic          w_match;

    assign w_in_accept = i_in_valid && !o_in_stall;

    // Slots searched: section_count saturated at the table depth.
    assign w_lim = (32'(r_section_count) > SECTION_SLOTS) ? CW'(SECTION_SLOTS)
                                                            : CW'(r_section_count);

    assign w_header    = r_rva < r_header_size;
    assign w_cache_hit = (r_rva >= r_win_start) && ({1'b0, r_rva} < r_win_end);
    assign w_slot_end  = {1'b0, r_rd_data.virtual_start} + {1'b0, r_rd_data.raw_size};
    assign w_match     = r_rd_valid && (r_rva >= r_rd_data.virtual_start)
                         && ({1'b0, r_rva} < w_slot_end);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_accept && i_in_data.command == CMD_TRANSLATE) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (w_header || w_cache_hit || w_lim == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (w_match || (r_rd_valid && r_rd_last)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_in_stall = 1'b1;
        w_issue    = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            S_IDLE:   o_in_stall = 1'b0;
            S_CHECK:  ;
            S_SEARCH: w_issue = r_idx < w_lim;
            S_DONE:   w_out_load = !r_out_valid || !i_out_stall;
            default:  ;
        endcase
    end

    // Table write on a load, read while searching.
    always_ff @(posedge i_clk) begin
        if (w_in_accept && i_in_data.command == CMD_LOAD
                && 32'(i_in_data.slot) < SECTION_SLOTS) begin
            r_mem[AW'(i_in_data.slot)] <= '{
                virtual_start: i_in_data.section_virtual_start,
                raw_size:      i_in_data.section_raw_size,
                raw_pointer:   i_in_data.section_raw_pointer
            };
        end
        if (w_issue) begin
            r_rd_data <= r_mem[r_idx[AW-1:0]];
        end
    end

    // Transaction payload and result fields.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_rva  <= i_in_data.rva;
            r_base <= i_in_data.add_position + 64'(i_in_data.rva);
        end
        if (r_state == S_CHECK) begin
            r_hit    <= 1'b0;
            r_region <= REGION_NOT_FOUND;
            if (w_header) begin
                r_region <= REGION_HEADER;
            end else if (w_cache_hit) begin
                r_region <= REGION_SECTION;
                r_hit    <= 1'b1;
            end
        end else if (r_state == S_SEARCH && w_match) begin
            r_region <= REGION_SECTION;
        end
        if (w_out_load) begin
            r_out_data.raw_offset <= r_base + {{31{r_win_delta[32]}}, r_win_delta};
            r_out_data.region     <= r_region;
            r_out_data.cache_hit  <= r_hit;
        end
    end

    // Control, configuration and cached window.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_header_size   <= '0;
            r_section_count <= '0;
            r_win_start     <= '0;
            r_win_end       <= '0;
            r_win_delta     <= '0;
            r_idx           <= '0;
            r_rd_valid      <= 1'b0;
            r_rd_last       <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HEADER_SIZE:   r_header_size   <= i_cfg_data;
                    CFG_SECTION_COUNT: r_section_count <= i_cfg_data[4:0];
                    default:           ;
                endcase
            end

            if (r_state == S_CHECK) begin
                r_idx      <= '0;
                r_rd_valid <= 1'b0;
                // Everything but a cache hit outside the header leaves the window cleared unless a slot matches.
                if (w_header || !w_cache_hit) begin
                    r_win_start <= '0;
                    r_win_end   <= '0;
                    r_win_delta <= '0;
                end
            end else begin
                r_rd_valid <= w_issue;
                if (w_issue) begin
                    r_idx     <= r_idx + CW'(1);
                    r_rd_last <= (r_idx + CW'(1)) == w_lim;
                end
                if (r_state == S_SEARCH && w_match) begin
                    r_win_start <= r_rd_data.virtual_start;
                    r_win_end   <= w_slot_end;
                    r_win_delta <= {1'b0, r_rd_data.raw_pointer}
                                   - {1'b0, r_rd_data.virtual_start};
                end
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

[hw/rtl/srtfo_chk.sv]
// Port-level checker for the section RVA to file offset translator, and its bind.
// Depends on srtfo_pkg for the transaction structs and codes.
`default_nettype none

module srtfo_chk
    import srtfo_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire t_in_item    i_in_data,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire t_out_item   o_out_data,
    input wire logic        i_cfg_we,
    input wire logic        i_cfg_idx,
    input wire logic [31:0] i_cfg_data
);

    // A stalled result transaction stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // A cache hit is only ever reported inside a section.
    a_hit_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.cache_hit |-> o_out_data.region == REGION_SECTION)
        else $error("cache hit outside a section");

    // A load completes without leaving the idle state, so the input is free again in the next cycle.
    a_load_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.command == CMD_LOAD |=> !o_in_stall)
        else $error("load did not complete in one cycle");

    // A translate occupies the block for at least the following cycle.
    a_translate_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.command == CMD_TRANSLATE |=> o_in_stall)
        else $error("input taken while a translate is in flight");

endmodule

bind section_rva_to_file_offset srtfo_chk u_srtfo_chk (.*);

`default_nettype wire
